// File: sv/pngu_pkg.sv
// Shared constants and types for the PNG scanline unfilter unit.
package pngu_pkg;

  localparam int MAX_LINE_BYTES_DEF = 8192;
  localparam int PIX_MAX            = 8;
  localparam int SLOT_W             = 3;
  localparam int BPP_W              = 4;
  localparam int LEN_CFG_W          = 14;
  localparam int CFG_IDX_W          = 4;

  localparam logic [2:0] FILT_NONE  = 3'd0;
  localparam logic [2:0] FILT_SUB   = 3'd1;
  localparam logic [2:0] FILT_UP    = 3'd2;
  localparam logic [2:0] FILT_PAETH = 3'd4;
  localparam logic [2:0] FILT_BAD   = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_LINE_BYTES      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_PIXEL = 4'd1;

  // One filtered byte on its way from the sequencing stage to reconstruction
  typedef struct packed {
    logic [7:0]        data;
    logic [SLOT_W-1:0] slot;
    logic              a_zero;
    logic              first_row;
    logic [2:0]        filt;
    logic              last;
  } pngu_item_t;

endpackage

// File: sv/png_scanline_unfilter_unit.sv
// PNG scanline unfilter top level: handshakes, config registers, output register.
//
//  channel | dir | handshake           | payload
//  in_     | in  | in_tvalid/in_tready | tdata: data_byte, tuser: frame_start
//  out_    | out | out_tvalid/ready    | tdata: pixel_byte, tlast: line_end,
//          |     |                     | tuser: bad_filter
//  cfg_    | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One byte per clock sustained while out_tready is high. A filtered byte's
// line-store read is registered with the item, then reconstruction feeds
// the output register. The left-neighbor loop closes through the history
// registers. Reset is synchronous and needs no memory sweep.
// An output stall holds the item stage; input is taken while the output
// register drains in the same cycle.
module png_scanline_unfilter_unit #(
  parameter int   MAX_LINE_BYTES = pngu_pkg::MAX_LINE_BYTES_DEF,
  localparam int  IDX_W = (MAX_LINE_BYTES > 1) ? $clog2(MAX_LINE_BYTES) : 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] data_byte
  input  logic                           in_tuser,   // [0] frame_start
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata,  // [7:0] pixel_byte
  output logic                           out_tlast,
  output logic                           out_tuser,  // [0] bad_filter
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pngu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pngu_pkg::LEN_CFG_W-1:0] cfg_data
);

  logic [pngu_pkg::LEN_CFG_W-1:0] line_bytes_r;
  logic [pngu_pkg::BPP_W-1:0]     bpp_r;

  logic                 in_accept;
  logic                 s1_valid;
  logic                 s1_go;
  pngu_pkg::pngu_item_t s1_item;
  logic [IDX_W-1:0]     s1_idx;
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  logic [7:0]           rd_data;
  logic                 hist_clr;
  logic [7:0]           res_byte;
  logic                 res_bad;

  logic                 out_valid_r;
  logic [7:0]           out_byte_r;
  logic                 out_last_r;
  logic                 out_bad_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_bytes_r <= pngu_pkg::LEN_CFG_W'(1);
      bpp_r        <= pngu_pkg::BPP_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pngu_pkg::CFG_LINE_BYTES:      line_bytes_r <= cfg_data;
        pngu_pkg::CFG_BYTES_PER_PIXEL: bpp_r <= cfg_data[pngu_pkg::BPP_W-1:0];
        default: ;
      endcase
    end
  end

  assign s1_go     = s1_valid & (~out_valid_r | out_tready);
  assign in_tready = ~s1_valid | s1_go;
  assign in_accept = in_tvalid & in_tready;

  pngu_ctrl #(.MAX_LINE_BYTES(MAX_LINE_BYTES)) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .line_bytes      (line_bytes_r),
    .bytes_per_pixel (bpp_r),
    .in_accept       (in_accept),
    .in_data         (in_tdata),
    .in_frame_start  (in_tuser),
    .s1_go           (s1_go),
    .s1_valid        (s1_valid),
    .s1_item         (s1_item),
    .s1_idx          (s1_idx),
    .rd_en           (rd_en),
    .rd_addr         (rd_addr),
    .hist_clr        (hist_clr)
  );

  pngu_line_mem #(.MAX_LINE_BYTES(MAX_LINE_BYTES)) u_line_mem (
    .clk       (clk),
    .wr_en     (s1_go),
    .wr_addr   (s1_idx),
    .wr_data   (res_byte),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data)
  );

  pngu_recon u_recon (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_item  (s1_item),
    .rd_data  (rd_data),
    .s1_go    (s1_go),
    .hist_clr (hist_clr),
    .res_byte (res_byte),
    .res_bad  (res_bad)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_byte_r <= res_byte;
      out_last_r <= s1_item.last;
      out_bad_r  <= res_bad;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_bad_r;

  // a frame start byte is a filter byte and never reaches the item stage
  a_frame_start_no_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_tuser |=> !s1_valid)
    else $error("frame start byte produced an item");

  a_go_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go |=> out_tvalid)
    else $error("item moved but output register empty");

  a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 8'd0)
    else $error("unsupported filter line gave nonzero byte");

  a_stall_holds_item: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid && !s1_go |=> s1_valid && $stable(s1_item))
    else $error("stalled item changed");

endmodule

// File: sv/pngu_line_mem.sv
// Prior-row line store: one write port, one registered read port.
module pngu_line_mem #(
  parameter int   MAX_LINE_BYTES = pngu_pkg::MAX_LINE_BYTES_DEF,
  localparam int  IDX_W = (MAX_LINE_BYTES > 1) ? $clog2(MAX_LINE_BYTES) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [7:0]       wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [7:0]       rd_data_r
);

  logic [7:0] mem [MAX_LINE_BYTES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

// File: sv/pngu_ctrl.sv
// Line sequencing: filter byte decode, column and slot tracking, item register.
module pngu_ctrl #(
  parameter int   MAX_LINE_BYTES = pngu_pkg::MAX_LINE_BYTES_DEF,
  localparam int  IDX_W = (MAX_LINE_BYTES > 1) ? $clog2(MAX_LINE_BYTES) : 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [pngu_pkg::LEN_CFG_W-1:0] line_bytes,
  input  logic [pngu_pkg::BPP_W-1:0]     bytes_per_pixel,
  input  logic                           in_accept,
  input  logic [7:0]                     in_data,
  input  logic                           in_frame_start,
  input  logic                           s1_go,
  output logic                           s1_valid,
  output pngu_pkg::pngu_item_t           s1_item,
  output logic [IDX_W-1:0]               s1_idx,
  output logic                           rd_en,
  output logic [IDX_W-1:0]               rd_addr,
  output logic                           hist_clr
);

  logic                             expect_r, expect_nxt;
  logic                             first_row_r, first_row_nxt;
  logic [2:0]                       filt_r, filt_nxt;
  logic [IDX_W-1:0]                 idx_r, idx_nxt;
  logic [pngu_pkg::SLOT_W-1:0]      mod_r   [pngu_pkg::PIX_MAX];
  logic [pngu_pkg::SLOT_W-1:0]      mod_nxt [pngu_pkg::PIX_MAX];
  logic                             s1_valid_r, s1_valid_nxt;
  pngu_pkg::pngu_item_t             s1_item_r, s1_item_nxt;
  logic [IDX_W-1:0]                 s1_idx_r, s1_idx_nxt;

  logic [pngu_pkg::BPP_W-1:0]       bpp_eff;
  logic [pngu_pkg::BPP_W-1:0]       bpp_m1;
  logic [31:0]                      lb_ext;
  logic [IDX_W-1:0]                 len_m1;
  logic                             is_filter;
  logic                             is_last;
  logic                             a_zero;
  logic [2:0]                       filt_dec;

  always_comb begin
    if (bytes_per_pixel == '0) begin
      bpp_eff = pngu_pkg::BPP_W'(1);
    end else if (32'(bytes_per_pixel) > 32'(pngu_pkg::PIX_MAX)) begin
      bpp_eff = pngu_pkg::BPP_W'(pngu_pkg::PIX_MAX);
    end else begin
      bpp_eff = bytes_per_pixel;
    end
    bpp_m1 = bpp_eff - pngu_pkg::BPP_W'(1);

    lb_ext = 32'(line_bytes);
    if (lb_ext == 32'd0) begin
      len_m1 = '0;
    end else if (lb_ext > 32'(MAX_LINE_BYTES)) begin
      len_m1 = IDX_W'(MAX_LINE_BYTES - 1);
    end else begin
      len_m1 = IDX_W'(lb_ext - 32'd1);
    end
  end

  assign is_filter = expect_r | in_frame_start;
  assign is_last   = (idx_r >= len_m1);
  assign a_zero    = (32'(idx_r) < 32'(bpp_eff));

  always_comb begin
    unique case (in_data) inside
      pngu_pkg::FILT_NONE, pngu_pkg::FILT_SUB, pngu_pkg::FILT_UP,
      pngu_pkg::FILT_PAETH: filt_dec = in_data[2:0];
      default:              filt_dec = pngu_pkg::FILT_BAD;
    endcase
  end

  always_comb begin
    expect_nxt    = expect_r;
    first_row_nxt = first_row_r;
    filt_nxt      = filt_r;
    idx_nxt       = idx_r;
    mod_nxt       = mod_r;
    s1_valid_nxt  = s1_go ? 1'b0 : s1_valid_r;
    s1_item_nxt   = s1_item_r;
    s1_idx_nxt    = s1_idx_r;

    if (in_accept) begin
      if (is_filter) begin
        if (in_frame_start) begin
          first_row_nxt = 1'b1;
        end
        filt_nxt   = filt_dec;
        expect_nxt = 1'b0;
        idx_nxt    = '0;
        for (int k = 0; k < pngu_pkg::PIX_MAX; k++) begin
          mod_nxt[k] = '0;
        end
      end else begin
        s1_valid_nxt          = 1'b1;
        s1_item_nxt.data      = in_data;
        s1_item_nxt.slot      = mod_r[bpp_m1[pngu_pkg::SLOT_W-1:0]];
        s1_item_nxt.a_zero    = a_zero;
        s1_item_nxt.first_row = first_row_r;
        s1_item_nxt.filt      = filt_r;
        s1_item_nxt.last      = is_last;
        s1_idx_nxt            = idx_r;
        if (is_last) begin
          expect_nxt    = 1'b1;
          first_row_nxt = 1'b0;
        end else begin
          idx_nxt = idx_r + 1'b1;
          // position modulo k+1 kept for every pixel size at once
          for (int k = 0; k < pngu_pkg::PIX_MAX; k++) begin
            mod_nxt[k] = (mod_r[k] == pngu_pkg::SLOT_W'(k)) ? '0 : mod_r[k] + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_r    <= 1'b1;
      first_row_r <= 1'b1;
      filt_r      <= pngu_pkg::FILT_NONE;
      idx_r       <= '0;
      s1_valid_r  <= 1'b0;
      for (int k = 0; k < pngu_pkg::PIX_MAX; k++) begin
        mod_r[k] <= '0;
      end
    end else begin
      expect_r    <= expect_nxt;
      first_row_r <= first_row_nxt;
      filt_r      <= filt_nxt;
      idx_r       <= idx_nxt;
      s1_valid_r  <= s1_valid_nxt;
      mod_r       <= mod_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_item_r <= s1_item_nxt;
    s1_idx_r  <= s1_idx_nxt;
  end

  assign s1_valid = s1_valid_r;
  assign s1_item  = s1_item_r;
  assign s1_idx   = s1_idx_r;
  assign rd_en    = in_accept & ~is_filter;
  assign rd_addr  = idx_r;
  assign hist_clr = in_accept & is_filter;

endmodule

// File: sv/pngu_recon.sv
// Byte reconstruction: left/up-left history and the None, Sub, Up, Paeth datapath.
module pngu_recon (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pngu_pkg::pngu_item_t s1_item,
  input  logic [7:0]           rd_data,
  input  logic                 s1_go,
  input  logic                 hist_clr,
  output logic [7:0]           res_byte,
  output logic                 res_bad
);

  logic [7:0]                  left_r [pngu_pkg::PIX_MAX];
  logic [7:0]                  upl_r  [pngu_pkg::PIX_MAX];
  logic [pngu_pkg::PIX_MAX-1:0] hv_r, hv_nxt;

  logic [7:0]        a, b, c, pred;
  logic              hist_ok;
  logic signed [9:0] sa, sb, sc, p, da, db, dc;
  logic signed [9:0] pa, pb, pc;

  assign hist_ok = hv_r[s1_item.slot] & ~s1_item.a_zero;
  assign a = hist_ok ? left_r[s1_item.slot] : 8'd0;
  assign b = s1_item.first_row ? 8'd0 : rd_data;
  assign c = (hist_ok && !s1_item.first_row) ? upl_r[s1_item.slot] : 8'd0;

  always_comb begin
    sa = signed'({2'b00, a});
    sb = signed'({2'b00, b});
    sc = signed'({2'b00, c});
    p  = sa + sb - sc;
    da = p - sa;
    db = p - sb;
    dc = p - sc;
    pa = (da < 0) ? -da : da;
    pb = (db < 0) ? -db : db;
    pc = (dc < 0) ? -dc : dc;
    if (pa <= pb && pa <= pc) begin
      pred = a;
    end else if (pb <= pc) begin
      pred = b;
    end else begin
      pred = c;
    end
  end

  always_comb begin
    res_bad = 1'b0;
    case (s1_item.filt)
      pngu_pkg::FILT_NONE:  res_byte = s1_item.data;
      pngu_pkg::FILT_SUB:   res_byte = s1_item.data + a;
      pngu_pkg::FILT_UP:    res_byte = s1_item.data + b;
      pngu_pkg::FILT_PAETH: res_byte = s1_item.data + pred;
      default: begin
        res_byte = 8'd0;
        res_bad  = 1'b1;
      end
    endcase
  end

  // line start clears after the previous line's last write
  always_comb begin
    hv_nxt = hv_r;
    if (s1_go) begin
      hv_nxt[s1_item.slot] = 1'b1;
    end
    if (hist_clr) begin
      hv_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r <= '0;
    end else begin
      hv_r <= hv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      left_r[s1_item.slot] <= res_byte;
      upl_r[s1_item.slot]  <= b;
    end
  end

endmodule

// File: sim/tb_png_scanline_unfilter_unit.sv
// Self-checking testbench for png_scanline_unfilter_unit: byte stream in, rebuilt scanlines out.
module tb_png_scanline_unfilter_unit;

  localparam logic [2:0]                     FILT_AVERAGE   = 3'd3;
  localparam logic [7:0]                     FILT_BYTE_MAX  = 8'hFF;
  localparam logic [pngu_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 4'd15;
  localparam int RANDOM_ITEMS = 700;
  localparam int WIDE_BYTES   = 400;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 400;

  typedef struct packed {
    logic [7:0] data;
    logic       frame_start;
  } stream_byte_t;

  typedef struct {
    logic [7:0] pixel;
    logic       line_end;
    logic       bad_filter;
  } recon_byte_t;

  typedef enum {RX_STREAM, RX_MOSTLY, RX_HALF, RX_SPARSE} rx_mode_e;

  // Tracks the unfilter state and holds the rebuilt bytes still owed by the block
  class unfilter_scoreboard;
    recon_byte_t    pixel_expect_q[$];
    bit [7:0]       prior_row[pngu_pkg::MAX_LINE_BYTES_DEF];
    bit [7:0]       left_hist[pngu_pkg::PIX_MAX];
    bit [7:0]       upleft_hist[pngu_pkg::PIX_MAX];
    int unsigned    column;
    logic [2:0]     line_filter;
    bit             first_row;
    logic [13:0]    line_bytes_reg;
    logic [3:0]     bpp_reg;
    int unsigned    written_upto;
    int             mismatch_cnt;

    function new();
      line_bytes_reg = 14'd1;
      bpp_reg        = 4'd1;
      column         = 0;
      line_filter    = pngu_pkg::FILT_NONE;
      first_row      = 1'b1;
      written_upto   = 0;
      mismatch_cnt   = 0;
      foreach (left_hist[i]) begin
        left_hist[i]   = '0;
        upleft_hist[i] = '0;
      end
    endfunction

    function void write_reg(logic [pngu_pkg::CFG_IDX_W-1:0] idx, logic [13:0] val);
      if (idx == pngu_pkg::CFG_LINE_BYTES) line_bytes_reg = val;
      else if (idx == pngu_pkg::CFG_BYTES_PER_PIXEL) bpp_reg = val[3:0];
    endfunction

    function int unsigned eff_len();
      if (line_bytes_reg == 0) return 1;
      if (line_bytes_reg > pngu_pkg::MAX_LINE_BYTES_DEF) return pngu_pkg::MAX_LINE_BYTES_DEF;
      return 32'(line_bytes_reg);
    endfunction

    function int unsigned eff_bpp();
      if (bpp_reg == 0) return 1;
      if (bpp_reg > pngu_pkg::PIX_MAX) return pngu_pkg::PIX_MAX;
      return 32'(bpp_reg);
    endfunction

    function logic [7:0] paeth_pick(logic [7:0] a, logic [7:0] b, logic [7:0] c);
      int p, pa, pb, pc;
      p  = int'(a) + int'(b) - int'(c);
      pa = p - int'(a);
      pb = p - int'(b);
      pc = p - int'(c);
      if (pa < 0) pa = -pa;
      if (pb < 0) pb = -pb;
      if (pc < 0) pc = -pc;
      if (pa <= pb && pa <= pc) return a;
      if (pb <= pc) return b;
      return c;
    endfunction

    function void note_stream_byte(logic [7:0] x, logic fs);
      int unsigned len, bpp, idx, slot;
      logic [7:0]  a, b, c, r;
      recon_byte_t exp_byte;
      len = eff_len();
      bpp = eff_bpp();
      if (fs) begin
        first_row = 1'b1;
        column    = 0;
      end
      if (column == 0) begin
        // filter type byte: no output, restart the left/up-left history
        if (x <= {5'd0, pngu_pkg::FILT_PAETH} && x != {5'd0, FILT_AVERAGE})
          line_filter = x[2:0];
        else
          line_filter = pngu_pkg::FILT_BAD;
        foreach (left_hist[i]) begin
          left_hist[i]   = '0;
          upleft_hist[i] = '0;
        end
        column = 1;
        return;
      end
      idx = column - 1;
      if (idx >= pngu_pkg::MAX_LINE_BYTES_DEF) idx = pngu_pkg::MAX_LINE_BYTES_DEF - 1;
      slot = idx % bpp;
      a = (idx < bpp) ? 8'd0 : left_hist[slot];
      b = first_row ? 8'd0 : prior_row[idx];
      c = (first_row || idx < bpp) ? 8'd0 : upleft_hist[slot];
      exp_byte.bad_filter = 1'b0;
      case (line_filter)
        pngu_pkg::FILT_NONE:  r = x;
        pngu_pkg::FILT_SUB:   r = x + a;
        pngu_pkg::FILT_UP:    r = x + b;
        pngu_pkg::FILT_PAETH: r = x + paeth_pick(a, b, c);
        default: begin
          r = 8'd0;
          exp_byte.bad_filter = 1'b1;
        end
      endcase
      left_hist[slot]   = r;
      upleft_hist[slot] = b;
      prior_row[idx]    = r;
      if (idx + 1 > written_upto) written_upto = idx + 1;
      exp_byte.pixel    = r;
      exp_byte.line_end = (idx + 1 >= len);
      if (exp_byte.line_end) begin
        column    = 0;
        first_row = 1'b0;
      end else begin
        column = column + 1;
      end
      pixel_expect_q.push_back(exp_byte);
    endfunction

    function void check_pixel(logic [7:0] pixel, logic line_end, logic bad_filter);
      recon_byte_t e;
      if (pixel_expect_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected output transaction: pixel %02h last %0b bad %0b",
                   pixel, line_end, bad_filter);
        return;
      end
      e = pixel_expect_q.pop_front();
      if (pixel !== e.pixel || line_end !== e.line_end || bad_filter !== e.bad_filter) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("output mismatch: expected pixel %02h last %0b bad %0b, got %02h %0b %0b",
                   e.pixel, e.line_end, e.bad_filter, pixel, line_end, bad_filter);
      end
    endfunction
  endclass

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [7:0]                     in_tdata   = '0;  // [7:0] data_byte
  logic                           in_tuser   = 1'b0; // [0] frame_start
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [7:0]                     out_tdata;  // [7:0] pixel_byte
  logic                           out_tlast;
  logic                           out_tuser;  // [0] bad_filter
  logic                           cfg_valid  = 1'b0;
  logic                           cfg_ready;
  logic [pngu_pkg::CFG_IDX_W-1:0] cfg_index  = '0;
  logic [pngu_pkg::LEN_CFG_W-1:0] cfg_data   = '0;

  unfilter_scoreboard sb;
  stream_byte_t       stream_q[$];
  bit                 hold_req = 1'b0;

  png_scanline_unfilter_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Both channels sampled on the pre-edge values
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_pixel(out_tdata, out_tlast, out_tuser);
      if (in_tvalid && in_tready) sb.note_stream_byte(in_tdata, in_tuser);
    end
  end

  initial begin : rx_pattern
    rx_mode_e mode;
    int       span;
    forever begin
      mode = rx_mode_e'($urandom_range(0, 3));
      span = $urandom_range(16, 256);
      repeat (span) begin
        @(posedge clk);
        case (mode)
          RX_STREAM: out_tready <= 1'b1;
          RX_MOSTLY: out_tready <= ($urandom_range(0, 3) != 0);
          RX_HALF:   out_tready <= 1'($urandom_range(0, 1));
          default:   out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
      if (hold_req) begin
        // long back-pressure: the sender keeps offering until the block stalls
        hold_req = 1'b0;
        @(posedge clk);
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_filter();
    case ($urandom_range(0, 15))
      0, 1, 2:     return {5'd0, pngu_pkg::FILT_NONE};
      3, 4, 5:     return {5'd0, pngu_pkg::FILT_SUB};
      6, 7, 8:     return {5'd0, pngu_pkg::FILT_UP};
      9, 10, 11, 12: return {5'd0, pngu_pkg::FILT_PAETH};
      13:          return {5'd0, FILT_AVERAGE};
      default:     return 8'($urandom_range(5, 255));
    endcase
  endfunction

  function automatic void push_item(logic [7:0] data, logic fs);
    stream_byte_t s;
    s.data        = data;
    s.frame_start = fs;
    stream_q.push_back(s);
  endfunction

  function automatic void push_line(logic fs, logic [7:0] filt, int unsigned n);
    push_item(filt, fs);
    repeat (n) push_item(rand_byte(), 1'b0);
  endfunction

  task automatic configure(logic [13:0] len_val, logic [13:0] bpp_val);
    cfg_valid <= 1'b1;
    cfg_index <= pngu_pkg::CFG_LINE_BYTES;
    cfg_data  <= len_val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(pngu_pkg::CFG_LINE_BYTES, len_val);
    cfg_index <= pngu_pkg::CFG_BYTES_PER_PIXEL;
    cfg_data  <= bpp_val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(pngu_pkg::CFG_BYTES_PER_PIXEL, bpp_val);
    if ($urandom_range(0, 2) == 0) begin
      cfg_index <= CFG_UNUSED_IDX;
      cfg_data  <= 14'($urandom());
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  // Sender: random bursts, random gaps, some long unbroken runs
  task automatic send_stream();
    int burst_left, gap;
    burst_left = $urandom_range(1, 16);
    for (int i = 0; i < stream_q.size(); i++) begin
      in_tvalid <= 1'b1;
      in_tdata  <= stream_q[i].data;
      in_tuser  <= stream_q[i].frame_start;
      do @(posedge clk); while (!in_tready);
      burst_left--;
      if (i == stream_q.size() - 1) begin
        in_tvalid <= 1'b0;
      end else if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 400)
                                                 : $urandom_range(1, 16);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          in_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    stream_q.delete();
  endtask

  // A trailing filter byte makes no output, so allow the pipeline to settle
  task automatic drain();
    while (sb.pixel_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int          random_items;
    int unsigned eff;
    logic [13:0] len_val, bpp_val;
    bit          start_fs;
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset config: one byte per line, every filter and the unsupported ones
    push_item({5'd0, pngu_pkg::FILT_NONE}, 1'b1);  push_item(8'hFF, 1'b0);
    push_item({5'd0, pngu_pkg::FILT_SUB}, 1'b0);   push_item(8'h00, 1'b0);
    push_item({5'd0, pngu_pkg::FILT_UP}, 1'b0);    push_item(8'hFF, 1'b0);
    push_item({5'd0, pngu_pkg::FILT_PAETH}, 1'b0); push_item(8'h80, 1'b0);
    push_item({5'd0, FILT_AVERAGE}, 1'b0);         push_item(8'h12, 1'b0);
    push_item(FILT_BYTE_MAX, 1'b0);                push_item(8'h34, 1'b0);
    push_item({5'd0, pngu_pkg::FILT_BAD}, 1'b0);   push_item(8'h56, 1'b0);
    send_stream();
    drain();

    // zero length and zero pixel size both count as one
    configure(14'd0, 14'd0);
    push_line(1'b0, {5'd0, pngu_pkg::FILT_PAETH}, 1);
    push_line(1'b0, {5'd0, pngu_pkg::FILT_UP}, 1);
    send_stream();
    drain();

    // line length shrunk in the middle of a line
    configure(14'd6, 14'd2);
    push_line(1'b1, {5'd0, pngu_pkg::FILT_PAETH}, 3);
    send_stream();
    drain();
    configure(14'd2, 14'd2);
    push_item(rand_byte(), 1'b0);
    push_line(1'b0, {5'd0, pngu_pkg::FILT_SUB}, 2);
    send_stream();
    drain();

    // oversized length and pixel size saturate; the long line stays open
    configure(14'h3FFF, 14'd15);
    push_line(1'b1, pick_filter(), WIDE_BYTES);
    hold_req = 1'b1;
    send_stream();
    drain();

    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0:       len_val = 14'd0;
        1:       len_val = 14'($urandom_range(100, 300));
        default: len_val = 14'($urandom_range(1, 24));
      endcase
      bpp_val = ($urandom_range(0, 1) == 0) ? 14'($urandom_range(1, 8)) : 14'($urandom());
      configure(len_val, bpp_val);
      eff = sb.eff_len();
      // a row longer than any row stored so far must begin a fresh image
      start_fs = (eff > sb.written_upto) || ($urandom_range(0, 5) == 0);
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(0, 9))
          0: repeat ($urandom_range(1, 8)) push_item(rand_byte(), $urandom_range(0, 5) == 0);
          1: push_line(1'($urandom_range(0, 1)), pick_filter(), $urandom_range(0, eff - 1));
          default: push_line(1'b0, pick_filter(), eff);
        endcase
      end
      if ($urandom_range(0, 3) == 0) push_line(1'b0, pick_filter(), $urandom_range(0, eff - 1));
      if (start_fs) stream_q[0].frame_start = 1'b1;
      random_items += stream_q.size();
      send_stream();
      drain();
    end

    if (sb.mismatch_cnt == 0 && sb.pixel_expect_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
